>>> hdl/dgi_pkg.sv
// Shared constants and the front-to-back command type for disparity gap interpolation.
package dgi_pkg;

   localparam int DISP_BITS   = 8;
   localparam int IN_BITS     = DISP_BITS + 1;
   localparam int X2_BITS     = DISP_BITS + 2;
   localparam int GAP_BOUND   = 63;
   localparam int RUN_BITS    = 6;
   localparam int LIMIT_BITS  = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DISP_BITS-1:0]     DISCON_LIMIT = DISP_BITS'(3);
   localparam logic [LIMIT_BITS-1:0]    GAP_LIMIT_RESET = LIMIT_BITS'(3);
   localparam logic [LIMIT_BITS-1:0]    GAP_LIMIT_MAX = LIMIT_BITS'(GAP_BOUND);
   localparam logic [CSR_ADDR_BITS-1:0] REG_GAP_LIMIT = CSR_ADDR_BITS'(0);
   localparam logic signed [X2_BITS-1:0] INVALID_X2 = X2_BITS'(-2);

   // One command: rep_count copies of the run value, then a single tail item.
   typedef struct packed {
      logic [RUN_BITS-1:0]       rep_count;
      logic signed [X2_BITS-1:0] rep_x2;
      logic                      rep_filled;
      logic signed [X2_BITS-1:0] tail_x2;
      logic                      tail_rend;
   } cmd_type;

endpackage

>>> hdl/dgi_front.sv
// Front end: classifies each pixel, tracks the open run and issues commands.
module dgi_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic signed [dgi_pkg::IN_BITS-1:0] disparity,
   input  logic                           row_end,
   input  logic [dgi_pkg::LIMIT_BITS-1:0] gap_limit,
   output logic                           push,
   output dgi_pkg::cmd_type               cmd
);
   import dgi_pkg::*;

   logic [DISP_BITS-1:0] left_value_ff, left_value_in;
   logic                 left_seen_ff, left_seen_in;
   logic [RUN_BITS-1:0]  run_count_ff, run_count_in;
   logic                 run_overflow_ff, run_overflow_in;

   logic                 negative;
   logic [DISP_BITS-1:0] d;
   logic [DISP_BITS-1:0] diff;
   logic [DISP_BITS-1:0] smaller;
   logic [DISP_BITS:0]   pair_sum;
   logic [X2_BITS-1:0]   fill_x2;
   logic [RUN_BITS:0]    run_next;
   logic [LIMIT_BITS-1:0] limit;
   logic                 emit;

   assign negative = disparity[IN_BITS-1];
   assign d        = disparity[DISP_BITS-1:0];
   assign limit    = (gap_limit > GAP_LIMIT_MAX) ? GAP_LIMIT_MAX : gap_limit;
   assign diff     = (left_value_ff > d) ? (left_value_ff - d) : (d - left_value_ff);
   assign smaller  = (left_value_ff < d) ? left_value_ff : d;
   assign pair_sum = {1'b0, left_value_ff} + {1'b0, d};
   assign fill_x2  = (diff < DISCON_LIMIT) ? {1'b0, pair_sum} : {1'b0, smaller, 1'b0};
   assign run_next = {1'b0, run_count_ff} + (RUN_BITS+1)'(1);

   always_comb begin
      left_value_in   = left_value_ff;
      left_seen_in    = left_seen_ff;
      run_count_in    = run_count_ff;
      run_overflow_in = run_overflow_ff;
      emit            = 1'b0;
      cmd.rep_count   = '0;
      cmd.rep_x2      = INVALID_X2;
      cmd.rep_filled  = 1'b0;
      cmd.tail_x2     = INVALID_X2;
      cmd.tail_rend   = row_end;
      if (!negative) begin
         emit            = 1'b1;
         cmd.rep_count   = run_count_ff;
         cmd.rep_x2      = fill_x2;
         cmd.rep_filled  = 1'b1;
         cmd.tail_x2     = {1'b0, d, 1'b0};
         run_count_in    = '0;
         run_overflow_in = 1'b0;
         left_value_in   = d;
         left_seen_in    = 1'b1;
      end else if (!left_seen_ff || run_overflow_ff) begin
         emit = 1'b1;
      end else if ((run_next > {1'b0, limit}) || row_end) begin
         // held run gives up: flush it as invalid, this pixel is the tail
         emit            = 1'b1;
         cmd.rep_count   = run_count_ff;
         run_count_in    = '0;
         run_overflow_in = 1'b1;
      end else begin
         run_count_in = run_next[RUN_BITS-1:0];
      end
      if (row_end) begin
         left_value_in   = '0;
         left_seen_in    = 1'b0;
         run_count_in    = '0;
         run_overflow_in = 1'b0;
      end
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_value_ff   <= '0;
         left_seen_ff    <= 1'b0;
         run_count_ff    <= '0;
         run_overflow_ff <= 1'b0;
      end else if (accept) begin
         left_value_ff   <= left_value_in;
         left_seen_ff    <= left_seen_in;
         run_count_ff    <= run_count_in;
         run_overflow_ff <= run_overflow_in;
      end
   end

endmodule

>>> hdl/dgi_queue.sv
// Short command queue between the front and back ends.
module dgi_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dgi_pkg::cmd_type push_cmd,
   input  logic             pop,
   output dgi_pkg::cmd_type head,
   output logic             not_empty,
   output logic             not_full
);
   import dgi_pkg::*;

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign not_full  = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/dgi_back.sv
// Back end: expands queued commands into result items through an output register.
module dgi_back (
   input  logic                               clock,
   input  logic                               reset,
   input  dgi_pkg::cmd_type                   head,
   input  logic                               head_valid,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [dgi_pkg::X2_BITS-1:0] rsp_disparity_x2,
   output logic                               rsp_was_filled,
   output logic                               rsp_row_end_out,
   output logic                               rsp_last
);
   import dgi_pkg::*;

   logic [RUN_BITS-1:0]       idx_ff, idx_in;
   logic                      valid_ff, valid_in;
   logic signed [X2_BITS-1:0] x2_ff, x2_in;
   logic                      filled_ff, filled_in;
   logic                      rend_ff, rend_in;
   logic                      last_ff, last_in;
   logic                      advance;
   logic                      in_reps;

   assign advance = !valid_ff || rsp_ready;
   assign in_reps = (idx_ff != head.rep_count);

   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      x2_in     = x2_ff;
      filled_in = filled_ff;
      rend_in   = rend_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (advance) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (in_reps) begin
               x2_in     = head.rep_x2;
               filled_in = head.rep_filled;
               rend_in   = 1'b0;
               last_in   = 1'b0;
               idx_in    = idx_ff + RUN_BITS'(1);
            end else begin
               x2_in     = head.tail_x2;
               filled_in = 1'b0;
               rend_in   = head.tail_rend;
               last_in   = 1'b1;
               idx_in    = '0;
               pop       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x2_ff     <= x2_in;
      filled_ff <= filled_in;
      rend_ff   <= rend_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_disparity_x2 = x2_ff;
   assign rsp_was_filled   = filled_ff;
   assign rsp_row_end_out  = rend_ff;
   assign rsp_last         = last_ff;

endmodule

>>> hdl/disparity_gap_interpolation.sv
// Path: an item's first result passes through the command queue and the output register.
// Throughput: one item per cycle accepted while the 4-entry command queue has room;
//   one result per cycle leaves the output register while rsp_ready is high, so an item
//   flushing a run of N held pixels yields N+1 results and the queue absorbs the burst.
// Reset (synchronous, active high) empties the queue and output, clears row state
//   and sets gap_limit to 3.
module disparity_gap_interpolation (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [dgi_pkg::IN_BITS-1:0]  req_disparity,
   input  logic                                req_row_end,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dgi_pkg::X2_BITS-1:0]  rsp_disparity_x2,
   output logic                                rsp_was_filled,
   output logic                                rsp_row_end_out,
   output logic                                rsp_last,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dgi_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [dgi_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [dgi_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import dgi_pkg::*;

   // gap limit register
   logic [LIMIT_BITS-1:0] gap_limit_ff, gap_limit_in;
   logic                  csr_write;

   // front/back plumbing
   logic    req_accept;
   logic    cmd_push;
   cmd_type cmd;
   cmd_type head;
   logic    q_not_empty;
   logic    q_not_full;
   logic    cmd_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == REG_GAP_LIMIT);
   assign gap_limit_in = csr_write ? csr_pwdata[LIMIT_BITS-1:0] : gap_limit_ff;
   assign csr_prdata   = (csr_paddr == REG_GAP_LIMIT)
                         ? {{(CSR_DATA_BITS-LIMIT_BITS){1'b0}}, gap_limit_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff <= GAP_LIMIT_RESET;
      end else begin
         gap_limit_ff <= gap_limit_in;
      end
   end

   // Accept whenever the queue has a free slot; held pixels need no slot but
   // are gated the same way to keep the ready path short.
   assign req_ready  = q_not_full;
   assign req_accept = req_valid && req_ready;

   dgi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .disparity (req_disparity),
      .row_end   (req_row_end),
      .gap_limit (gap_limit_ff),
      .push      (cmd_push),
      .cmd       (cmd)
   );

   dgi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (cmd),
      .pop       (cmd_pop),
      .head      (head),
      .not_empty (q_not_empty),
      .not_full  (q_not_full)
   );

   // back end replays the head command, popping it with its tail item
   dgi_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_valid       (q_not_empty),
      .pop              (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_disparity_x2 (rsp_disparity_x2),
      .rsp_was_filled   (rsp_was_filled),
      .rsp_row_end_out  (rsp_row_end_out),
      .rsp_last         (rsp_last)
   );

endmodule

>>> hdl/dgi_checker.sv
// Port-level checks for disparity_gap_interpolation and the bind that attaches them.
module dgi_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [dgi_pkg::X2_BITS-1:0] rsp_disparity_x2,
   input logic                               rsp_was_filled,
   input logic                               rsp_row_end_out,
   input logic                               rsp_last
);
   import dgi_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_disparity_x2)
      && $stable(rsp_last) && $stable(rsp_was_filled))
      else $error("result changed while stalled");

   // fills come before the closing pixel, never as the final item
   a_fill_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_filled |-> !rsp_last)
      else $error("filled item flagged last");

   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_end_out |-> rsp_last && !rsp_was_filled)
      else $error("row end not on final item");

   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_filled |-> !rsp_disparity_x2[X2_BITS-1])
      else $error("filled item carries invalid disparity");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind disparity_gap_interpolation dgi_checker u_dgi_checker (.*);
